### rtl/rual_pkg.sv
// shared types and constants for the route update admission limiter
package rual_pkg;

  localparam int CONTEXTS_DEFAULT = 64;
  localparam int CTX_W = 6;
  localparam int GEN_W = 32;
  localparam int CAND_W = 16;
  localparam int TIME_W = 48;
  localparam int LEVEL_W = 40;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [STATUS_W-1:0] ST_ADMITTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_QUAL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DWELL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BUDGET    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RECORDED  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CONS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BURST    = 3'd4;

  localparam logic [LEVEL_W-1:0] ONE_TOKEN = 40'h00_0100_0000;

  typedef struct packed {
    logic                  cmd;
    logic [CTX_W-1:0]      ctx;
    logic [GEN_W-1:0]      gen;
    logic [CAND_W-1:0]     cand;
    logic [TIME_W-1:0]     now;
  } item_t;

  typedef struct packed {
    logic                  suppress;
    logic [7:0]            min_cons;
    logic [31:0]           dwell;
    logic [31:0]           refill;
    logic [LEVEL_W-1:0]    burst;
  } cfg_t;

endpackage

### rtl/rual_front.sv
// input side: word capture and a two-entry queue towards the back end
module rual_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rual_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output rual_pkg::item_t q_item
);
  import rual_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### rtl/rual_back.sv
// back end: context table, qualification, dwell and token bucket
module rual_back #(
  parameter int CONTEXTS = rual_pkg::CONTEXTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rual_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  rual_pkg::item_t               q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rual_pkg::STATUS_W-1:0] out_status,
  output logic [rual_pkg::LEVEL_W-1:0]  out_level
);
  import rual_pkg::*;

  localparam int AW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_MUL_LO = 3'd2;
  localparam logic [2:0] S_MUL_HI = 3'd3;
  localparam logic [2:0] S_REFILL = 3'd4;
  localparam logic [2:0] S_TAKE   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [GEN_W+CAND_W+TIME_W-1:0]  act_mem  [CONTEXTS];
  logic [GEN_W+CAND_W+8-1:0]       pend_mem [CONTEXTS];
  logic [CONTEXTS-1:0]             act_vld;
  logic [CONTEXTS-1:0]             pend_vld;

  logic [2:0]                      state;
  item_t                           cur;
  logic [GEN_W+CAND_W+TIME_W-1:0]  act_rd;
  logic [GEN_W+CAND_W+8-1:0]       pend_rd;
  logic                            act_hit;
  logic                            pend_hit;
  logic [LEVEL_W-1:0]              level;
  logic [TIME_W-1:0]               last_time;
  logic                            started;
  logic [TIME_W-1:0]               delta;
  logic [71:0]                     product;
  logic [STATUS_W-1:0]             status;

  logic                            inrange;
  logic                            q_inrange;
  logic [AW-1:0]                   addr;
  logic [AW-1:0]                   q_addr;
  logic [GEN_W-1:0]                a_gen;
  logic [CAND_W-1:0]               a_cand;
  logic [TIME_W-1:0]               a_time;
  logic [GEN_W-1:0]                p_gen;
  logic [CAND_W-1:0]               p_cand;
  logic [7:0]                      p_cnt;
  logic                            is_dup;
  logic                            pend_match;
  logic [7:0]                      cnt_next;
  logic                            not_qual;
  logic                            dwell_block;
  logic                            use_bucket;
  logic [TIME_W:0]                 since;
  logic [23:0]                     mul_a;
  logic [55:0]                     mul_out;
  logic                            sat;
  logic [41:0]                     sum;
  logic [LEVEL_W-1:0]              refilled;
  logic                            wr_pend;
  logic                            clr_pend;

  assign q_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_status = status;
  assign out_level = level;

  assign q_addr = AW'(q_item.ctx);
  assign q_inrange = ({26'd0, q_item.ctx} < 32'(CONTEXTS));
  assign inrange = ({26'd0, cur.ctx} < 32'(CONTEXTS));
  assign addr = AW'(cur.ctx);
  assign {a_gen, a_cand, a_time} = act_rd;
  assign {p_gen, p_cand, p_cnt} = pend_rd;

  assign is_dup = act_hit && cfg.suppress && (a_gen == cur.gen) && (a_cand == cur.cand);
  assign pend_match = pend_hit && (p_gen == cur.gen) && (p_cand == cur.cand);
  assign cnt_next = !pend_match ? 8'd1 : ((p_cnt == 8'hff) ? p_cnt : p_cnt + 8'd1);
  assign not_qual = (cfg.min_cons > 8'd1) && (cnt_next < cfg.min_cons);
  assign since = {1'b0, cur.now} - {1'b0, a_time};
  assign dwell_block = act_hit && (cfg.dwell != 32'd0) &&
                       (since[TIME_W] || (since[TIME_W-1:0] < {16'd0, cfg.dwell}));
  assign use_bucket = !cur.cmd && !is_dup && !not_qual && !dwell_block &&
                      (cfg.refill != 32'd0);
  assign wr_pend = (state == S_EVAL) && !cur.cmd && !is_dup && (cfg.min_cons > 8'd1) && inrange;
  assign clr_pend = (state == S_EVAL) && inrange && (cur.cmd || is_dup);

  // elapsed time times rate, low part of the elapsed time in S_MUL_LO, then high part in S_MUL_HI
  assign mul_a = (state == S_MUL_HI) ? {8'd0, delta[39:24]} : delta[23:0];
  assign mul_out = mul_a * cfg.refill;

  // anything at or above 2^41 is past any burst, so it saturates
  assign sat = (delta[TIME_W-1:LEVEL_W] != '0) || (product[71:41] != '0);
  assign sum = {2'b0, level} + product[41:0];
  assign refilled = (sat || (sum > {2'b0, cfg.burst})) ? cfg.burst : sum[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      act_rd  <= act_mem[q_addr];
      pend_rd <= pend_mem[q_addr];
    end
    if (state == S_EVAL && cur.cmd && inrange) begin
      act_mem[addr] <= {cur.gen, cur.cand, cur.now};
    end
    if (wr_pend) begin
      pend_mem[addr] <= {cur.gen, cur.cand, cnt_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act_vld <= '0;
      pend_vld <= '0;
      level <= '0;
      last_time <= '0;
      started <= 1'b0;
      act_hit <= 1'b0;
      pend_hit <= 1'b0;
      status <= ST_ADMITTED;
      cur <= '0;
      delta <= '0;
      product <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            act_hit <= q_inrange && act_vld[q_addr];
            pend_hit <= q_inrange && pend_vld[q_addr];
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (cur.cmd && inrange) begin
            act_vld[addr] <= 1'b1;
          end
          if (clr_pend) begin
            pend_vld[addr] <= 1'b0;
          end else if (wr_pend) begin
            pend_vld[addr] <= 1'b1;
          end
          state <= S_DONE;
          if (cur.cmd) begin
            status <= ST_RECORDED;
          end else if (is_dup) begin
            status <= ST_DUPLICATE;
          end else if (not_qual) begin
            status <= ST_NOT_QUAL;
          end else if (dwell_block) begin
            status <= ST_DWELL;
          end else if (!use_bucket) begin
            status <= ST_ADMITTED;
          end else if (!started) begin
            started <= 1'b1;
            last_time <= cur.now;
            level <= cfg.burst;
            state <= S_TAKE;
          end else if (cur.now > last_time) begin
            delta <= cur.now - last_time;
            last_time <= cur.now;
            state <= S_MUL_LO;
          end else begin
            state <= S_TAKE;
          end
        end
        S_MUL_LO: begin
          product <= {16'd0, mul_out};
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          product <= product + {mul_out[47:0], 24'd0};
          state <= S_REFILL;
        end
        S_REFILL: begin
          level <= refilled;
          state <= S_TAKE;
        end
        S_TAKE: begin
          if (level < ONE_TOKEN) begin
            status <= ST_BUDGET;
          end else begin
            level <= level - ONE_TOKEN;
            status <= ST_ADMITTED;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/route_update_admission_limiter.sv
// a word passes from the input queue into the back end, which reads the table, evaluates
// in S_EVAL and offers the result in S_DONE; a token take adds S_TAKE, and elapsed time
// adds S_MUL_LO, S_MUL_HI and S_REFILL before it; the back end takes a new word only when
// idle, after its last result word is accepted, so a result that is not taken stalls it
// input queue of two words keeps accepting while the back end works, until it is full
// reset: synchronous, clears table valid bits, bucket and configuration to defaults
module route_update_admission_limiter #(
  parameter int CONTEXTS = rual_pkg::CONTEXTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rual_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rual_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [5:0]                      context_index,
  input  logic [31:0]                     generation,
  input  logic [15:0]                     candidate_id,
  input  logic [47:0]                     now_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic [39:0]                     token_level
);
  import rual_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  assign cfg_ready = 1'b1;
  assign in_item = '{cmd: cmd, ctx: context_index, gen: generation,
                     cand: candidate_id, now: now_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{suppress: 1'b1, min_cons: 8'd1, dwell: '0, refill: '0, burst: '0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SUPPRESS: cfg.suppress <= cfg_data[0];
        REG_MIN_CONS: cfg.min_cons <= cfg_data[7:0];
        REG_DWELL:    cfg.dwell <= cfg_data[31:0];
        REG_REFILL:   cfg.refill <= cfg_data[31:0];
        REG_BURST:    cfg.burst <= cfg_data;
        default: ;
      endcase
    end
  end

  rual_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  rual_back #(.CONTEXTS(CONTEXTS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(status), .out_level(token_level)
  );

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_RECORDED) else $error("status out of range");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(status) && $stable(token_level)))
    else $error("result word changed while waiting");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule
